### rtl/lctd_pkg.sv
package lctd_pkg;

    // Fixed field widths
    localparam int SAMPLE_BITS    = 24;
    localparam int LIMIT_W        = 23;
    localparam int K_W            = 4;
    localparam int K2_W           = 2 * K_W;
    localparam int CNT_CFG_W      = 12;
    localparam int RUN_W          = 8;
    localparam int EVT_W          = 3;

    // Defaults for the top-level parameters
    localparam int COUNT_MAX_DEF  = 4095;
    localparam int MEAN_FRAC_DEF  = 8;

    // Shared arithmetic unit: operand width and iteration counter width
    localparam int ARITH_W        = 64;
    localparam int ITER_W         = $clog2(ARITH_W + 1);

    // Configuration port
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = LIMIT_W;

    localparam logic [CFG_IDX_W-1:0] REG_ABS_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEV_MULT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STUCK_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ABORT_COUNT = 3'd4;

    localparam logic [LIMIT_W-1:0]   RST_ABS_LIMIT   = 23'd1048576;
    localparam logic [K_W-1:0]       RST_DEV_MULT    = 4'd6;
    localparam logic [CNT_CFG_W-1:0] RST_MIN_COUNT   = 12'd40;
    localparam logic [RUN_W-1:0]     RST_STUCK_LIMIT = 8'd40;
    localparam logic [CNT_CFG_W-1:0] RST_ABORT_COUNT = 12'd800;

    // Event codes
    localparam logic [EVT_W-1:0] EVT_NONE      = 3'd0;
    localparam logic [EVT_W-1:0] EVT_DEVIATION = 3'd1;
    localparam logic [EVT_W-1:0] EVT_STUCK     = 3'd2;
    localparam logic [EVT_W-1:0] EVT_ABORT     = 3'd3;
    localparam logic [EVT_W-1:0] EVT_ABSOLUTE  = 3'd4;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          start_request;
    } in_item_t;

    typedef struct packed {
        logic             probe_out;
        logic [EVT_W-1:0] event_code;
        logic             probing_active;
    } out_item_t;

    typedef struct packed {
        logic [LIMIT_W-1:0]   abs_limit;
        logic [K_W-1:0]       dev_mult;
        logic [CNT_CFG_W-1:0] min_count;
        logic [RUN_W-1:0]     stuck_limit;
        logic [CNT_CFG_W-1:0] abort_count;
    } cfg_t;

    typedef enum logic {
        ARITH_MUL,
        ARITH_DIV
    } arith_op_t;

    typedef struct packed {
        logic              start;
        arith_op_t         op;
        logic [ITER_W-1:0] iters;
    } arith_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } arith_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_TEST_VAR,
        ST_TEST_RHS,
        ST_TEST_LHS,
        ST_PUSH_Q,
        ST_PUSH_D2,
        ST_PUSH_M2,
        ST_DONE
    } seq_state_t;

endpackage

### rtl/lctd_cfg_regs.sv
module lctd_cfg_regs import lctd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index, ignore unknown ones
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write_en) begin
            case (cfg_index)
                REG_ABS_LIMIT:   cfg_next.abs_limit   = cfg_data[LIMIT_W-1:0];
                REG_DEV_MULT:    cfg_next.dev_mult    = cfg_data[K_W-1:0];
                REG_MIN_COUNT:   cfg_next.min_count   = cfg_data[CNT_CFG_W-1:0];
                REG_STUCK_LIMIT: cfg_next.stuck_limit = cfg_data[RUN_W-1:0];
                REG_ABORT_COUNT: cfg_next.abort_count = cfg_data[CNT_CFG_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.abs_limit   <= RST_ABS_LIMIT;
            cfg_reg.dev_mult    <= RST_DEV_MULT;
            cfg_reg.min_count   <= RST_MIN_COUNT;
            cfg_reg.stuck_limit <= RST_STUCK_LIMIT;
            cfg_reg.abort_count <= RST_ABORT_COUNT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/lctd_arith_unit.sv
module lctd_arith_unit import lctd_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  arith_req_t           req,
    input  logic [ARITH_W-1:0]   op_a,
    input  logic [ARITH_W-1:0]   op_b,
    output arith_stat_t          stat,
    output logic [2*ARITH_W-1:0] product,
    output logic [ARITH_W-1:0]   quotient
);

    localparam int ACC_W = 2 * ARITH_W;

    arith_op_t         op_reg;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]  mcand_reg, mcand_next;
    logic [ARITH_W-1:0] mplier_reg, mplier_next;

    logic [ACC_W:0]     add_a, add_b, sum;
    logic               cin;
    logic [ARITH_W:0]   trial;
    logic               fits;
    logic [ITER_W-1:0]  shamt;

    // One shared adder: shift-add step or restoring divide step
    always_comb begin
        trial = {acc_reg[ARITH_W-1:0], mplier_reg[ARITH_W-1]};
        if (op_reg == ARITH_DIV) begin
            add_a = (ACC_W + 1)'(trial);
            add_b = ~((ACC_W + 1)'(mcand_reg[ARITH_W-1:0]));
            cin   = 1'b1;
        end else begin
            add_a = {1'b0, acc_reg};
            add_b = mplier_reg[0] ? {1'b0, mcand_reg} : '0;
            cin   = 1'b0;
        end
        sum  = add_a + add_b + (ACC_W + 1)'(cin);
        fits = ~sum[ACC_W];
    end

    // Load operands on start, step while busy
    always_comb begin
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        shamt       = ITER_W'(ARITH_W) - req.iters;
        if (req.start) begin
            cnt_next   = req.iters;
            busy_next  = 1'b1;
            acc_next   = '0;
            if (req.op == ARITH_DIV) begin
                mcand_next  = ACC_W'(op_b);
                mplier_next = op_a << shamt;
            end else begin
                mcand_next  = ACC_W'(op_a);
                mplier_next = op_b;
            end
        end else if (busy_reg) begin
            cnt_next = cnt_reg - ITER_W'(1);
            if (cnt_reg == ITER_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            if (op_reg == ARITH_DIV) begin
                acc_next    = fits ? ACC_W'(sum[ARITH_W:0]) : ACC_W'(trial);
                mplier_next = {mplier_reg[ARITH_W-2:0], fits};
            end else begin
                acc_next    = sum[ACC_W-1:0];
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ARITH_MUL;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            if (req.start) begin
                op_reg <= req.op;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = acc_reg;
    assign quotient  = mplier_reg;

endmodule

### rtl/load_cell_touch_detector_top.sv
// Load-cell touch detector: each request carries one signed sample and a start flag and
// yields exactly one result (probe level, event code, probing state). A running count,
// mean (MEAN_FRAC_BITS fraction bits) and squared-deviation sum (4 fraction bits) are
// kept with the Welford update; while probing, once minimum_count samples are held, a
// sample beyond deviation_multiple sigmas raises the probe and is not accumulated. All
// division and multiplication runs on one shared shift-add/restoring-divide unit, one
// bit per cycle, and the block takes no new request while it works. With D = 24 +
// MEAN_FRAC_BITS + 2 (34 by default), the variance divide runs 64 steps, and the mean
// divide and the deviation products run D steps each.
// The next request is taken while a finished result still waits at the output.
module load_cell_touch_detector_top import lctd_pkg::*; #(
    parameter int COUNT_MAX      = COUNT_MAX_DEF,
    parameter int MEAN_FRAC_BITS = MEAN_FRAC_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_payload,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int X_W    = SAMPLE_BITS + MEAN_FRAC_BITS;
    localparam int MEAN_W = X_W + 1;
    localparam int D_W    = MEAN_W + 1;
    localparam int CNT_W  = $clog2(COUNT_MAX + 1);
    localparam int CC_W   = (CNT_W > CNT_CFG_W) ? CNT_W : CNT_CFG_W;
    localparam int LSH    = (2 * MEAN_FRAC_BITS < 4) ? 4 - 2 * MEAN_FRAC_BITS : 0;
    localparam int RSH    = (2 * MEAN_FRAC_BITS >= 4) ? 2 * MEAN_FRAC_BITS - 4 : 0;
    localparam int P_W    = 2 * ARITH_W + LSH;
    localparam int CMP_W  = 2 * ARITH_W + LSH + RSH;
    localparam int RHS_W  = ARITH_W + K2_W;

    cfg_t                 cfg;
    arith_req_t           arith_req;
    arith_stat_t          arith_stat;
    logic [ARITH_W-1:0]   arith_a, arith_b;
    logic [2*ARITH_W-1:0] product;
    logic [ARITH_W-1:0]   quotient;

    lctd_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    lctd_arith_unit u_arith (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (arith_req),
        .op_a     (arith_a),
        .op_b     (arith_b),
        .stat     (arith_stat),
        .product  (product),
        .quotient (quotient)
    );

    // Sequencer and statistics state
    seq_state_t               state_reg, state_next;
    logic                     probing_reg, probing_next;
    logic                     out_level_reg, out_level_next;
    logic [RUN_W-1:0]         run_reg, run_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic signed [MEAN_W-1:0] mean_reg, mean_next;
    logic [ARITH_W-1:0]       m2_reg, m2_next;
    logic                     m_valid_reg, m_valid_next;

    // Per-request working registers
    logic signed [X_W-1:0]    x_reg, x_next;
    logic                     abs_hit_reg, abs_hit_next;
    logic [D_W-1:0]           dm_reg, dm_next;
    logic                     d_neg_reg, d_neg_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [RHS_W-1:0]         rhs_reg, rhs_next;
    logic                     check_abort_reg, check_abort_next;
    logic [EVT_W-1:0]         event_reg, event_next;
    out_item_t                m_payload_reg, m_payload_next;

    // Datapath helpers
    logic signed [X_W-1:0]    x_in;
    logic signed [SAMPLE_BITS:0] s_ext;
    logic [SAMPLE_BITS:0]     s_mag;
    logic signed [D_W-1:0]    x_d, mean_d, d_cur, q_s, new_mean_d;
    logic [D_W-1:0]           dm_cur;
    logic [CNT_W-1:0]         n_cur, div_cnt;
    logic                     count_ge_min;
    logic [K2_W-1:0]          k2;
    logic [CMP_W-1:0]         lhs_al, rhs_al;
    logic                     oob;
    logic [RUN_W-1:0]         run_inc;
    logic [P_W-1:0]           p_full, p_al;
    logic [ARITH_W:0]         m2_sum;
    logic                     m2_sat;

    // Sample scaling, deviation from the current mean, and the tests
    always_comb begin
        x_in   = X_W'($signed(s_payload.sample)) <<< MEAN_FRAC_BITS;
        s_ext  = (SAMPLE_BITS + 1)'($signed(s_payload.sample));
        s_mag  = s_ext[SAMPLE_BITS] ? $unsigned(-s_ext) : $unsigned(s_ext);

        x_d    = D_W'(x_reg);
        mean_d = D_W'(mean_reg);
        d_cur  = x_d - mean_d;
        dm_cur = d_cur[D_W-1] ? $unsigned(-d_cur) : $unsigned(d_cur);

        n_cur   = (count_reg < CNT_W'(COUNT_MAX)) ? count_reg + CNT_W'(1) : count_reg;
        div_cnt = (count_reg >= CNT_W'(2)) ? count_reg - CNT_W'(1) : CNT_W'(1);
        count_ge_min = CC_W'(count_reg) >= CC_W'(cfg.min_count);
        k2 = K2_W'(cfg.dev_mult) * K2_W'(cfg.dev_mult);

        lhs_al = CMP_W'(product) << LSH;
        rhs_al = CMP_W'(rhs_reg) << RSH;
        oob    = lhs_al > rhs_al;
        run_inc = (run_reg != '1) ? run_reg + RUN_W'(1) : run_reg;

        q_s        = $signed(quotient[D_W-1:0]);
        new_mean_d = d_neg_reg ? mean_d - q_s : mean_d + q_s;

        p_full = P_W'(product) << LSH;
        p_al   = p_full >> RSH;
        m2_sum = {1'b0, m2_reg} + {1'b0, p_al[ARITH_W-1:0]};
        m2_sat = (|p_al[P_W-1:ARITH_W]) || m2_sum[ARITH_W];
    end

    // Next state and unit requests
    always_comb begin
        state_next       = state_reg;
        probing_next     = probing_reg;
        out_level_next   = out_level_reg;
        run_next         = run_reg;
        count_next       = count_reg;
        mean_next        = mean_reg;
        m2_next          = m2_reg;
        m_valid_next     = m_valid_reg;
        x_next           = x_reg;
        abs_hit_next     = abs_hit_reg;
        dm_next          = dm_reg;
        d_neg_next       = d_neg_reg;
        n_next           = n_reg;
        rhs_next         = rhs_reg;
        check_abort_next = check_abort_reg;
        event_next       = event_reg;
        m_payload_next   = m_payload_reg;
        arith_req.start  = 1'b0;
        arith_req.op     = ARITH_MUL;
        arith_req.iters  = '0;
        arith_a          = '0;
        arith_b          = '0;
        s_ready          = 1'b0;

        // Drop the result once it is taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    x_next       = x_in;
                    abs_hit_next = s_mag > (SAMPLE_BITS + 1)'(cfg.abs_limit);
                    probing_next = probing_reg | s_payload.start_request;
                    state_next   = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                dm_next          = dm_cur;
                d_neg_next       = d_cur[D_W-1];
                n_next           = n_cur;
                event_next       = EVT_NONE;
                check_abort_next = 1'b0;
                arith_req.start  = 1'b1;
                arith_req.op     = ARITH_DIV;
                if (probing_reg && count_ge_min) begin
                    // Variance = M2 / (count - 1)
                    arith_req.iters = ITER_W'(ARITH_W);
                    arith_a         = m2_reg;
                    arith_b         = ARITH_W'(div_cnt);
                    state_next      = ST_TEST_VAR;
                end else begin
                    if (!probing_reg) begin
                        out_level_next = abs_hit_reg;
                        event_next     = abs_hit_reg ? EVT_ABSOLUTE : EVT_NONE;
                    end
                    arith_req.iters = ITER_W'(D_W);
                    arith_a         = ARITH_W'(dm_cur);
                    arith_b         = ARITH_W'(n_cur);
                    state_next      = ST_PUSH_Q;
                end
            end
            ST_TEST_VAR: begin
                if (arith_stat.done) begin
                    arith_req.start = 1'b1;
                    arith_req.op    = ARITH_MUL;
                    arith_req.iters = ITER_W'(K2_W);
                    arith_a         = quotient;
                    arith_b         = ARITH_W'(k2);
                    state_next      = ST_TEST_RHS;
                end
            end
            ST_TEST_RHS: begin
                if (arith_stat.done) begin
                    rhs_next        = product[RHS_W-1:0];
                    arith_req.start = 1'b1;
                    arith_req.op    = ARITH_MUL;
                    arith_req.iters = ITER_W'(D_W);
                    arith_a         = ARITH_W'(dm_reg);
                    arith_b         = ARITH_W'(dm_reg);
                    state_next      = ST_TEST_LHS;
                end
            end
            ST_TEST_LHS: begin
                if (arith_stat.done) begin
                    if (oob) begin
                        if (run_inc >= cfg.stuck_limit) begin
                            // Stuck outside the band: release and clear
                            run_next       = '0;
                            out_level_next = 1'b0;
                            probing_next   = 1'b0;
                            count_next     = '0;
                            mean_next      = '0;
                            m2_next        = '0;
                            event_next     = EVT_STUCK;
                        end else begin
                            run_next       = run_inc;
                            out_level_next = 1'b1;
                            event_next     = EVT_DEVIATION;
                        end
                        state_next = ST_DONE;
                    end else begin
                        out_level_next   = 1'b0;
                        run_next         = '0;
                        check_abort_next = 1'b1;
                        arith_req.start  = 1'b1;
                        arith_req.op     = ARITH_DIV;
                        arith_req.iters  = ITER_W'(D_W);
                        arith_a          = ARITH_W'(dm_reg);
                        arith_b          = ARITH_W'(n_reg);
                        state_next       = ST_PUSH_Q;
                    end
                end
            end
            ST_PUSH_Q: begin
                if (arith_stat.done) begin
                    mean_next  = new_mean_d[MEAN_W-1:0];
                    state_next = ST_PUSH_D2;
                end
            end
            ST_PUSH_D2: begin
                // d * (x - new mean), magnitudes
                arith_req.start = 1'b1;
                arith_req.op    = ARITH_MUL;
                arith_req.iters = ITER_W'(D_W);
                arith_a         = ARITH_W'(dm_reg);
                arith_b         = ARITH_W'(dm_cur);
                state_next      = ST_PUSH_M2;
            end
            ST_PUSH_M2: begin
                if (arith_stat.done) begin
                    m2_next    = m2_sat ? '1 : m2_sum[ARITH_W-1:0];
                    count_next = n_reg;
                    if (check_abort_reg && (CC_W'(n_reg) > CC_W'(cfg.abort_count))) begin
                        probing_next = 1'b0;
                        event_next   = EVT_ABORT;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_payload_next.probe_out      = out_level_reg;
                    m_payload_next.event_code     = event_reg;
                    m_payload_next.probing_active = probing_reg;
                    m_valid_next                  = 1'b1;
                    state_next                    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            probing_reg   <= 1'b0;
            out_level_reg <= 1'b0;
            run_reg       <= '0;
            count_reg     <= '0;
            mean_reg      <= '0;
            m2_reg        <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            probing_reg   <= probing_next;
            out_level_reg <= out_level_next;
            run_reg       <= run_next;
            count_reg     <= count_next;
            mean_reg      <= mean_next;
            m2_reg        <= m2_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg           <= x_next;
        abs_hit_reg     <= abs_hit_next;
        dm_reg          <= dm_next;
        d_neg_reg       <= d_neg_next;
        n_reg           <= n_next;
        rhs_reg         <= rhs_next;
        check_abort_reg <= check_abort_next;
        event_reg       <= event_next;
        m_payload_reg   <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // The shared unit is never restarted while it is still stepping
    a_start_idle_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        arith_req.start |-> !arith_stat.busy)
        else $error("arith unit started while busy");

    // A finished operation always finds the sequencer waiting for it
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        arith_stat.done |-> (state_reg == ST_TEST_VAR || state_reg == ST_TEST_RHS ||
                             state_reg == ST_TEST_LHS || state_reg == ST_PUSH_Q ||
                             state_reg == ST_PUSH_M2))
        else $error("arith result arrived outside a wait state");

    // A stuck release leaves cleared statistics and probing off
    a_stuck_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && event_reg == EVT_STUCK) |->
        (count_reg == '0 && m2_reg == '0 && !probing_reg && !out_level_reg))
        else $error("stuck release did not clear state");

endmodule
